// ===== rtl/core/date_keyed_sorted_table_assert.svh =====
// ----------------------------------------------------------------------------
// date keyed sorted table assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DATE_KEYED_SORTED_TABLE_ASSERT_SVH
`define DATE_KEYED_SORTED_TABLE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define DKST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dkst check failed");

// next-cycle implication, clocked on clk, off during rst
`define DKST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dkst check failed");

`endif

// ===== rtl/core/dkst_pkg.sv =====
// ----------------------------------------------------------------------------
// dkst_pkg
// constants, types and date compare for the date keyed sorted table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dkst_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int DAYS_PER_YEAR = 426;

  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W     = 16;
  localparam int DAY_W    = 10;
  localparam int YEAR_W   = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;
  localparam int ENTRIES_W = 7;
  localparam int OP_W     = 2;

  localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_SORT   = 2'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DAY_W-1:0]  day;
    logic [YEAR_W-1:0] year;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    entry_t           x;
    logic [IDX_W-1:0] i;
    logic [CNT_W-1:0] n;
    logic [ID_W-1:0]  key;
    entry_t           rec;
  } ctrl_t;

  typedef struct packed {
    logic             found_any;
    logic             mark_any;
    logic [IDX_W-1:0] mark_pos;
    entry_t           next_x;
  } info_t;

  function automatic logic date_ok(entry_t e);
    return (e.day >= DAY_W'(1)) && (e.day <= DAY_W'(DAYS_PER_YEAR)) &&
           (e.year != '0);
  endfunction

  // year-major compare equals the linear day key for valid dates
  function automatic logic later_than(entry_t a, entry_t b);
    return date_ok(a) && date_ok(b) && ({a.year, a.day} > {b.year, b.day});
  endfunction

endpackage

// ===== rtl/core/dkst_cell.sv =====
// ----------------------------------------------------------------------------
// dkst_cell
// one table position: compare, shift toward either neighbor, append, pick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dkst_cell (
  input  logic                        clk,
  input  dkst_pkg::ctrl_t             ctrl,
  input  logic [dkst_pkg::IDX_W-1:0]  pos,
  input  dkst_pkg::entry_t            left_entry,
  input  dkst_pkg::entry_t            right_entry,
  input  logic                        run_l,
  input  logic                        run_r,
  input  logic                        found_l,
  output dkst_pkg::entry_t            entry,
  output logic                        run,
  output logic                        found,
  output logic                        mark,
  output dkst_pkg::entry_t            pick
);

  localparam int IW = dkst_pkg::IDX_W;
  localparam int CW = dkst_pkg::CNT_W;

  logic [IW:0]        pos_w;
  logic [IW:0]        i_w;
  logic               below;
  logic               tail;
  logic               hit;
  logic               is_sort;
  logic               is_del;
  dkst_pkg::entry_t   entry_next;

  assign pos_w   = {1'b0, pos};
  assign i_w     = {1'b0, ctrl.i};
  assign below   = pos_w < i_w;
  assign tail    = (pos_w + (IW+1)'(1)) == i_w;
  assign is_sort = ctrl.op == dkst_pkg::OP_SORT;
  assign is_del  = ctrl.op == dkst_pkg::OP_DELETE;
  assign hit     = (entry.id == ctrl.key) && (CW'(pos) < ctrl.n);

  // run: this cell holds an entry later than x in the unbroken run below i
  assign run   = is_sort && below && dkst_pkg::later_than(entry, ctrl.x) && (tail || run_r);
  assign found = is_del && (found_l || hit);
  assign mark  = (run && !run_l) || (is_del && hit && !found_l);
  assign pick  = (pos_w == i_w + (IW+1)'(1)) ? entry : '0;

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      dkst_pkg::OP_APPEND: begin
        if (CW'(pos) == ctrl.n) begin
          entry_next = ctrl.rec;
        end
      end
      dkst_pkg::OP_SORT: begin
        if (run && !run_l) begin
          entry_next = ctrl.x;
        end else if (run_l) begin
          entry_next = left_entry;
        end
      end
      dkst_pkg::OP_DELETE: begin
        if (found) begin
          entry_next = right_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== rtl/core/dkst_chain.sv =====
// ----------------------------------------------------------------------------
// dkst_chain
// row of table cells with neighbor links and result collection
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dkst_chain (
  input  logic             clk,
  input  dkst_pkg::ctrl_t  ctrl,
  output dkst_pkg::info_t  info
);

  localparam int DEPTH = dkst_pkg::TABLE_DEPTH;
  localparam int IW    = dkst_pkg::IDX_W;

  dkst_pkg::entry_t entries [DEPTH];
  dkst_pkg::entry_t picks   [DEPTH];
  logic [DEPTH-1:0] run_v;
  logic [DEPTH-1:0] found_v;
  logic [DEPTH-1:0] mark_v;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    dkst_pkg::entry_t le;
    dkst_pkg::entry_t re;
    logic             rl;
    logic             rr;
    logic             fl;

    if (k == 0) begin : g_first
      assign le = ctrl.x;
      assign rl = 1'b0;
      assign fl = 1'b0;
    end else begin : g_mid_l
      assign le = entries[k-1];
      assign rl = run_v[k-1];
      assign fl = found_v[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign re = entries[k];
      assign rr = 1'b0;
    end else begin : g_mid_r
      assign re = entries[k+1];
      assign rr = run_v[k+1];
    end

    dkst_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .pos         (IW'(k)),
      .left_entry  (le),
      .right_entry (re),
      .run_l       (rl),
      .run_r       (rr),
      .found_l     (fl),
      .entry       (entries[k]),
      .run         (run_v[k]),
      .found       (found_v[k]),
      .mark        (mark_v[k]),
      .pick        (picks[k])
    );
  end

  always_comb begin
    info           = '0;
    info.found_any = found_v[DEPTH-1];
    info.mark_any  = |mark_v;
    for (int k = 0; k < DEPTH; k++) begin
      if (mark_v[k]) begin
        info.mark_pos = info.mark_pos | IW'(k);
      end
      info.next_x = info.next_x | picks[k];
    end
  end

endmodule

// ===== rtl/core/date_keyed_sorted_table.sv =====
// ----------------------------------------------------------------------------
// date_keyed_sorted_table
// bounded record table kept in date order by a row of shifting cells
// ----------------------------------------------------------------------------
// A request either inserts a record (id, day, year) or deletes the first
// record with a given id, and each request returns exactly one result with
// status, slot and the new record count. An insert appends the record and
// then walks the records once, one position per cycle, letting each
// entry slide in one step past the run of later-dated cells in front of it.
// A delete finds the first match and closes the gap in all cells at once.
// An insert into a full table or into an empty one skips the walk. One
// request is in work at a time; a new request is taken while an earlier
// result still waits on the output. Table contents are not cleared at
// reset, only the count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module date_keyed_sorted_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [dkst_pkg::ID_W-1:0]         record_id,
  input  logic [dkst_pkg::DAY_W-1:0]        date_day,
  input  logic [dkst_pkg::YEAR_W-1:0]       date_year,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dkst_pkg::STATUS_W-1:0]     status,
  output logic [dkst_pkg::SLOT_W-1:0]       slot,
  output logic [dkst_pkg::ENTRIES_W-1:0]    entries_now
);

  localparam int IW = dkst_pkg::IDX_W;
  localparam int CW = dkst_pkg::CNT_W;
  localparam int SW = dkst_pkg::SLOT_W;
  localparam int EW = dkst_pkg::ENTRIES_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_SORT = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                      state;
  logic [CW-1:0]                   count;
  logic [IW-1:0]                   i;
  dkst_pkg::entry_t                x;
  logic [dkst_pkg::ID_W-1:0]       key;
  logic [dkst_pkg::STATUS_W-1:0]   res_status;
  logic [IW-1:0]                   res_slot;

  dkst_pkg::ctrl_t                 ctrl;
  dkst_pkg::info_t                 info;
  logic                            accept;
  logic                            full;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && !in_stall;
  assign full     = count >= CW'(dkst_pkg::TABLE_DEPTH);

  always_comb begin
    ctrl          = '0;
    ctrl.op       = dkst_pkg::OP_HOLD;
    ctrl.x        = x;
    ctrl.i        = i;
    ctrl.n        = count;
    ctrl.key      = key;
    ctrl.rec.id   = record_id;
    ctrl.rec.day  = date_day;
    ctrl.rec.year = date_year;
    case (state)
      S_IDLE: begin
        if (accept && action == dkst_pkg::ACT_INSERT && !full) begin
          ctrl.op = dkst_pkg::OP_APPEND;
        end
      end
      S_SORT:  ctrl.op = dkst_pkg::OP_SORT;
      S_DEL:   ctrl.op = dkst_pkg::OP_DELETE;
      default: ctrl.op = dkst_pkg::OP_HOLD;
    endcase
  end

  dkst_chain u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .info (info)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            key <= record_id;
            i   <= '0;
            if (action == dkst_pkg::ACT_DELETE) begin
              state <= S_DEL;
            end else if (full) begin
              res_status <= dkst_pkg::ST_FULL;
              res_slot   <= '0;
              state      <= S_FIN;
            end else begin
              count      <= count + CW'(1);
              res_status <= dkst_pkg::ST_DONE;
              res_slot   <= '0;
              state      <= (count == '0) ? S_FIN : S_LOAD;
            end
          end
        end
        S_LOAD: begin
          x     <= info.next_x;
          i     <= IW'(1);
          state <= S_SORT;
        end
        S_SORT: begin
          x <= info.next_x;
          i <= i + IW'(1);
          if (CW'(i) == count - CW'(1)) begin
            res_slot <= info.mark_any ? info.mark_pos : i;
            state    <= S_FIN;
          end
        end
        S_DEL: begin
          if (info.found_any) begin
            count      <= count - CW'(1);
            res_status <= dkst_pkg::ST_DONE;
            res_slot   <= info.mark_pos;
          end else begin
            res_status <= dkst_pkg::ST_NOTFOUND;
            res_slot   <= '0;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            slot        <= SW'(res_slot);
            entries_now <= EW'(count);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/dkst_checker.sv =====
// ----------------------------------------------------------------------------
// dkst_checker
// port-level checks on results of the date keyed sorted table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "date_keyed_sorted_table_assert.svh"

module dkst_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [dkst_pkg::STATUS_W-1:0]     status,
  input logic [dkst_pkg::SLOT_W-1:0]       slot,
  input logic [dkst_pkg::ENTRIES_W-1:0]    entries_now
);

  `DKST_ASSERT_IMP(a_count_max, out_valid, entries_now <= dkst_pkg::TABLE_DEPTH)
  `DKST_ASSERT_IMP(a_full_res, out_valid && status == dkst_pkg::ST_FULL,
                   entries_now == dkst_pkg::TABLE_DEPTH && slot == '0)
  `DKST_ASSERT_IMP(a_miss_res, out_valid && status == dkst_pkg::ST_NOTFOUND, slot == '0)
  `DKST_ASSERT_IMP(a_slot_rng, out_valid && status == dkst_pkg::ST_DONE, slot <= entries_now)
  `DKST_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(slot) && $stable(entries_now))

endmodule

bind date_keyed_sorted_table dkst_checker u_dkst_checker (.*);
